/* rtl/core/bae_pkg.sv */
// Shared types and constants for the button edge and auto-repeat block.
package bae_pkg;

	// Widths fixed by the stream and register formats
	localparam int FIELD_W   = 16;
	localparam int CNT_W     = 10;
	localparam int CFG_W     = 8;
	localparam int DIV_W     = 9;
	localparam int STEP_W    = $clog2(DIV_W + 1);
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int OUT_DW    = 4 * FIELD_W;

	localparam int NUM_BUTTONS_DEF = 16;

	localparam logic [CFG_W-1:0] FIRST_DELAY_RST     = 8'd20;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 8'd5;

	// Register index taken from the word address bit
	localparam logic REG_FIRST_DELAY     = 1'b0;
	localparam logic REG_REPEAT_INTERVAL = 1'b1;

	// Counter values with special meaning
	localparam logic signed [CNT_W-1:0] CNT_IDLE     = '0;
	localparam logic signed [CNT_W-1:0] CNT_FIRST    = CNT_W'(1);
	localparam logic signed [CNT_W-1:0] CNT_RELEASED = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD,
		ST_DONE
	} bae_state_t;

	// Status from the remainder unit back to the sequencer
	typedef struct packed {
		logic done;
		logic is_zero;
	} rem_stat_t;

endpackage

/* rtl/core/button_edge_and_auto_repeat.sv */
// Top level of the button edge detector with typematic auto-repeat.
//
//  port group  dir  beat contents (low bits first)
//  s_*         in   tdata[15:0] pressed_bits
//  m_*         out  tdata held_bits, press_edge_bits, release_edge_bits, repeat_bits
//  apb         in   word 0 first_delay, word 1 repeat_interval (8 bits each)
//
// Each beat scans the B = min(NUM_BUTTONS, 16) buttons one after another; a button
// held past first_delay with a nonzero repeat_interval also passes through the
// bit-serial remainder unit. The remainder unit bounds the rate.
// Reset clears all hold counters and loads the register defaults (20 and 5).
// The result register holds a finished beat while the next one is scanned; a stall
// on the output side only blocks once a second result is ready.
module button_edge_and_auto_repeat
	import bae_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// stream in: [15:0] pressed_bits
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [FIELD_W-1:0] s_tdata,
	// stream out: [15:0] held_bits, [31:16] press_edge_bits,
	// [47:32] release_edge_bits, [63:48] repeat_bits
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Buttons above the input width never see a press and stay at zero, so
	// only the visible ones get a counter.
	localparam int ACT   = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;
	localparam int IDX_W = (ACT > 1) ? $clog2(ACT) : 1;

	bae_state_t state_q, state_d;

	logic [CFG_W-1:0] first_delay_q, repeat_interval_q;
	logic signed [CNT_W-1:0] cnt_q [ACT];
	logic [ACT-1:0]     lvl_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FIELD_W-1:0] held_acc_q, press_acc_q, rel_acc_q, rep_acc_q;
	logic [OUT_DW-1:0]  out_q;
	logic               out_valid_q;

	logic cfg_wr, in_acc, out_acc;
	logic last_idx, advance, rem_start, out_load, scan_wr;
	logic [FIELD_W-1:0] sel;
	logic signed [CNT_W-1:0] cur, inc, lim, first_s, nc;
	logic need_mod;
	rem_stat_t rem_stat;

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q     <= FIRST_DELAY_RST;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FIRST_DELAY:     first_delay_q     <= pwdata[CFG_W-1:0];
				REG_REPEAT_INTERVAL: repeat_interval_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIRST_DELAY:     prdata = APB_DW'(first_delay_q);
			REG_REPEAT_INTERVAL: prdata = APB_DW'(repeat_interval_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- handshakes ----------------
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign out_acc  = m_tvalid && m_tready;

	// ---------------- per-button update ----------------
	assign last_idx = (idx_q == IDX_W'(ACT - 1));
	assign sel      = FIELD_W'(1) << idx_q;
	assign cur      = cnt_q[idx_q];
	assign inc      = cur + CNT_W'(1);
	assign first_s  = $signed(CNT_W'(first_delay_q));
	assign lim      = $signed(CNT_W'(first_delay_q) + CNT_W'(repeat_interval_q));

	always_comb begin
		if (lvl_q[idx_q]) begin
			// count up, fold back to first_delay past one full interval
			nc = (inc > lim) ? first_s : inc;
		end else begin
			nc = (cur > CNT_IDLE) ? CNT_RELEASED : CNT_IDLE;
		end
	end

	// periodic repeat needs nc mod repeat_interval; nc is positive here
	assign need_mod = lvl_q[idx_q] && (repeat_interval_q != '0) && (nc > first_s);

	bae_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (nc[DIV_W-1:0]),
		.divisor  (repeat_interval_q),
		.stat     (rem_stat)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		rem_start = 1'b0;
		out_load  = 1'b0;
		scan_wr   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				scan_wr = 1'b1;
				if (need_mod) begin
					rem_start = 1'b1;
					state_d   = ST_MOD;
				end else begin
					advance = 1'b1;
					state_d = last_idx ? ST_DONE : ST_SCAN;
				end
			end
			ST_MOD: begin
				if (rem_stat.done) begin
					advance = 1'b1;
					state_d = last_idx ? ST_DONE : ST_SCAN;
				end
			end
			ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// button index: restart on accept, advance after each button
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_acc) begin
			idx_q <= '0;
		end else if (advance && !last_idx) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// hold counters: written back during the scan cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACT; i++) cnt_q[i] <= CNT_IDLE;
		end else if (scan_wr) begin
			cnt_q[idx_q] <= nc;
		end
	end

	// latched levels and result bitmaps
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lvl_q      <= s_tdata[ACT-1:0];
			held_acc_q  <= '0;
			press_acc_q <= '0;
			rel_acc_q   <= '0;
			rep_acc_q   <= '0;
		end else begin
			if (scan_wr) begin
				if (nc > CNT_IDLE)     held_acc_q  <= held_acc_q | sel;
				if (nc == CNT_FIRST)    press_acc_q <= press_acc_q | sel;
				if (nc == CNT_RELEASED) rel_acc_q   <= rel_acc_q | sel;
				if (nc == CNT_FIRST)    rep_acc_q   <= rep_acc_q | sel;
			end
			if (state_q == ST_MOD && rem_stat.done && rem_stat.is_zero) begin
				rep_acc_q <= rep_acc_q | sel;
			end
		end
		if (out_load) begin
			out_q <= {rep_acc_q, rel_acc_q, press_acc_q, held_acc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- checks ----------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input taken while a beat is still in work");

	a_press_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2*FIELD_W-1:FIELD_W] & ~m_tdata[FIELD_W-1:0]) == '0))
		else $error("press edge without held bit");

	a_release_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[3*FIELD_W-1:2*FIELD_W] & m_tdata[FIELD_W-1:0]) == '0))
		else $error("release edge on a held button");

	a_press_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2*FIELD_W-1:FIELD_W] & ~m_tdata[OUT_DW-1:3*FIELD_W]) == '0))
		else $error("press edge without repeat event");

	a_mod_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |=> (state_q == ST_MOD))
		else $error("remainder started outside the modulo step");

	for (genvar g = 0; g < ACT; g++) begin : g_cnt_chk
		a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
			(cnt_q[g] >= CNT_RELEASED) && (cnt_q[g] <= $signed(CNT_W'(2 * ((1 << CFG_W) - 1)))))
			else $error("hold counter out of range");
	end

endmodule

/* rtl/core/bae_rem_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module bae_rem_unit
	import bae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [CFG_W-1:0]     divisor,
	output rem_stat_t            stat
);

	logic [DIV_W-1:0]  dvd_q;
	logic [CFG_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [DIV_W-1:0]  trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(DIV_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				done_q <= (step_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			// remainder stays below the divisor, so it fits the narrow register
			rem_q <= fits ? CFG_W'(trial - {1'b0, divisor}) : CFG_W'(trial);
		end
	end

	assign stat.done    = done_q;
	assign stat.is_zero = (rem_q == '0);

endmodule
